/* hw/rtl/y2r_pkg.sv */
// Shared widths, coefficients, types and the round/clamp helper of the YUY2 to RGB24 converter.
package y2r_pkg;

	// Product and sum widths (signed)
	localparam int ProdW = 18;
	localparam int SumW  = 20;
	localparam int PixW  = 8;

	// BT.601 studio-range coefficients
	localparam logic signed [ProdW-1:0] KLuma    = 18'sd298;
	localparam logic signed [ProdW-1:0] KRedV    = 18'sd409;
	localparam logic signed [ProdW-1:0] KGreenU  = 18'sd100;
	localparam logic signed [ProdW-1:0] KGreenV  = 18'sd208;
	localparam logic signed [ProdW-1:0] KBlueU   = 18'sd516;
	localparam logic signed [SumW-1:0]  KRound   = 20'sd128;
	localparam logic signed [9:0]       KLumaOff = 10'sd16;
	localparam logic [PixW-1:0]         PixMax   = 8'd255;

	// Chroma contributions shared by both pixels of a macropixel
	typedef struct packed {
		logic signed [ProdW-1:0] blue;
		logic signed [ProdW-1:0] green;
		logic signed [ProdW-1:0] red;
	} chroma_t;

	// One RGB pixel
	typedef struct packed {
		logic [PixW-1:0] blue;
		logic [PixW-1:0] green;
		logic [PixW-1:0] red;
	} pix_t;

	// Floor-shift by 8 and clamp to 0..255
	function automatic logic [PixW-1:0] round_clamp(input logic signed [SumW-1:0] sum);
		logic [PixW-1:0] res;
		if (sum[SumW-1]) begin
			res = '0;
		end else if (|sum[SumW-2:PixW+8]) begin
			res = PixMax;
		end else begin
			res = sum[PixW+7:8];
		end
		return res;
	endfunction

endpackage

/* hw/rtl/y2r_chroma.sv */
// Shared chroma stage: weighted U and V terms for all three channels, registered.
module y2r_chroma import y2r_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [7:0]     chroma_blue,
	input  logic [7:0]     chroma_red,
	output chroma_t        chroma_s1
);

	logic signed [7:0]       d_val;
	logic signed [7:0]       e_val;
	logic signed [ProdW-1:0] d_ext;
	logic signed [ProdW-1:0] e_ext;
	chroma_t                 chroma_d;

	// Offset by 128 is a flip of the top bit
	assign d_val = $signed({~chroma_blue[7], chroma_blue[6:0]});
	assign e_val = $signed({~chroma_red[7], chroma_red[6:0]});
	assign d_ext = ProdW'(d_val);
	assign e_ext = ProdW'(e_val);

	// Constant weights reduce to shift-add trees
	always_comb begin
		chroma_d.blue  = d_ext * KBlueU;
		chroma_d.green = -(d_ext * KGreenU) - (e_ext * KGreenV);
		chroma_d.red   = e_ext * KRedV;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chroma_s1 <= chroma_d;
		end
	end

endmodule

/* hw/rtl/y2r_lane.sv */
// One pixel lane: registered luma product, then sum with shared chroma, round and clamp.
module y2r_lane import y2r_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [7:0]     luma,
	input  chroma_t        chroma_s1,
	output pix_t           pix
);

	logic signed [9:0]       c_val;
	logic signed [ProdW-1:0] luma_s1;
	logic signed [SumW-1:0]  luma_w;

	assign c_val = $signed({2'b00, luma}) - KLumaOff;

	// Luma weight
	always_ff @(posedge clk) begin
		if (en) begin
			luma_s1 <= ProdW'(c_val) * KLuma;
		end
	end

	// Sum, round and clamp per channel
	assign luma_w = SumW'(luma_s1);
	always_comb begin
		pix.blue  = round_clamp(luma_w + SumW'(chroma_s1.blue) + KRound);
		pix.green = round_clamp(luma_w + SumW'(chroma_s1.green) + KRound);
		pix.red   = round_clamp(luma_w + SumW'(chroma_s1.red) + KRound);
	end

endmodule

/* hw/rtl/y2r_merge.sv */
// Merging stage: joins both lanes and the frame flag into the output register.
module y2r_merge import y2r_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  pix_t           pix_first,
	input  pix_t           pix_second,
	input  logic           frame_end_s1,
	input  logic           out_stall,
	output logic           load,
	output logic           out_valid,
	output logic [7:0]     blue_first,
	output logic [7:0]     green_first,
	output logic [7:0]     red_first,
	output logic [7:0]     blue_second,
	output logic [7:0]     green_second,
	output logic [7:0]     red_second,
	output logic           frame_end_out
);

	logic valid_s2;
	pix_t first_s2;
	pix_t second_s2;
	logic frame_end_s2;

	// Register takes new data when empty or when its transfer completes
	assign load = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_s2     <= pix_first;
			second_s2    <= pix_second;
			frame_end_s2 <= frame_end_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign blue_first    = first_s2.blue;
	assign green_first   = first_s2.green;
	assign red_first     = first_s2.red;
	assign blue_second   = second_s2.blue;
	assign green_second  = second_s2.green;
	assign red_second    = second_s2.red;
	assign frame_end_out = frame_end_s2;

endmodule

/* hw/rtl/yuy2_to_rgb24_converter.sv */
// YUY2 to RGB24 converter top level: two luma lanes, shared chroma, output register.
// Converts one YUY2 macropixel (Y0, U, Y1, V) per clock while in_stall is low into two
// BT.601 studio-range RGB pixels that share the chroma. There are two register stages:
// an input transfer is registered in stage 1 and then moves into stage 2, which drives
// out_valid. Stage 1 holds the weighted luma and chroma products, stage 2 is the output
// register fed by the per-lane sum, round and clamp. Throughput is one macropixel per
// cycle; in_stall rises only when both stages are full and the output is stalled.
// frame_end_in travels alongside the data unchanged.
module yuy2_to_rgb24_converter import y2r_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] luma_first,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] luma_second,
	input  logic [7:0] chroma_red,
	input  logic       frame_end_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] blue_first,
	output logic [7:0] green_first,
	output logic [7:0] red_first,
	output logic [7:0] blue_second,
	output logic [7:0] green_second,
	output logic [7:0] red_second,
	output logic       frame_end_out
);

	logic    valid_s1;
	logic    frame_end_s1;
	logic    load_s2;
	logic    en_s1;
	chroma_t chroma_s1;
	pix_t    pix_first;
	pix_t    pix_second;

	// Stage 1 advances when empty or when stage 2 takes its content
	assign in_stall = valid_s1 && !load_s2;
	assign en_s1    = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			frame_end_s1 <= frame_end_in;
		end
	end

	// Shared chroma terms
	y2r_chroma u_chroma (
		.clk         (clk),
		.en          (en_s1),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.chroma_s1   (chroma_s1)
	);

	// Pixel lanes
	y2r_lane u_lane_first (
		.clk       (clk),
		.en        (en_s1),
		.luma      (luma_first),
		.chroma_s1 (chroma_s1),
		.pix       (pix_first)
	);

	y2r_lane u_lane_second (
		.clk       (clk),
		.en        (en_s1),
		.luma      (luma_second),
		.chroma_s1 (chroma_s1),
		.pix       (pix_second)
	);

	// Merge into output register
	y2r_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.pix_first     (pix_first),
		.pix_second    (pix_second),
		.frame_end_s1  (frame_end_s1),
		.out_stall     (out_stall),
		.load          (load_s2),
		.out_valid     (out_valid),
		.blue_first    (blue_first),
		.green_first   (green_first),
		.red_first     (red_first),
		.blue_second   (blue_second),
		.green_second  (green_second),
		.red_second    (red_second),
		.frame_end_out (frame_end_out)
	);

endmodule

/* hw/rtl/y2r_checker.sv */
// Port-level checker for the YUY2 to RGB24 converter, bound to the top level.
module y2r_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] blue_first,
	input logic [7:0] green_first,
	input logic [7:0] red_first,
	input logic [7:0] blue_second,
	input logic [7:0] green_second,
	input logic [7:0] red_second,
	input logic       frame_end_out
);

	// Stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	// Stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(blue_first) && $stable(green_first)
			&& $stable(red_first) && $stable(blue_second) && $stable(green_second)
			&& $stable(red_second) && $stable(frame_end_out))
		else $error("output payload changed while stalled");

	// Input backs up only behind a held output transfer
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A fresh result must follow a matching earlier input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output appeared without matching input transfer");

endmodule

bind yuy2_to_rgb24_converter y2r_checker u_y2r_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.blue_first    (blue_first),
	.green_first   (green_first),
	.red_first     (red_first),
	.blue_second   (blue_second),
	.green_second  (green_second),
	.red_second    (red_second),
	.frame_end_out (frame_end_out)
);

/* tb/tb_yuy2_to_rgb24_converter.sv */
// Self-checking testbench of the YUY2 to RGB24 converter: directed and random macropixels.
module tb_yuy2_to_rgb24_converter;
	import y2r_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ClkPeriod  = 12;
	localparam int ResetCycles = 12;
	localparam int RandomItems = 500;
	localparam int MaxIdle     = 12;
	localparam int DrainCycles = 8;
	localparam int CycleLimit  = 200000;

	// Expected pixel pairs and the BT.601 integer conversion that produces them
	class rgb_scoreboard;
		typedef struct {
			pix_t first;
			pix_t second;
			logic frame_end;
		} pixel_pair_t;

		pixel_pair_t expected_q[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		// (sum + 128) floor-shifted by 8, clamped to a byte
		function logic [7:0] round_to_byte(int sum);
			int q;
			logic [7:0] res;
			q = (sum + 128) >>> 8;
			if (q < 0) begin
				res = 8'd0;
			end else if (q > 255) begin
				res = 8'd255;
			end else begin
				res = q[7:0];
			end
			return res;
		endfunction

		function pix_t convert_pixel(logic [7:0] luma, int d, int e);
			pix_t p;
			int c;
			c = int'(luma) - 16;
			p.blue  = round_to_byte(298 * c + 516 * d);
			p.green = round_to_byte(298 * c - 100 * d - 208 * e);
			p.red   = round_to_byte(298 * c + 409 * e);
			return p;
		endfunction

		// Accepted macropixel: queue the two pixels it must turn into
		function void note_input(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
				logic [7:0] v, logic fe);
			pixel_pair_t pp;
			int d;
			int e;
			d = int'(u) - 128;
			e = int'(v) - 128;
			pp.first     = convert_pixel(y0, d, e);
			pp.second    = convert_pixel(y1, d, e);
			pp.frame_end = fe;
			expected_q.push_back(pp);
		endfunction

		// Accepted output transfer: compare with the oldest expected pair
		function void check_result(pix_t first, pix_t second, logic fe);
			pixel_pair_t pp;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transfer: BGR %h %h end %b", first, second, fe);
				return;
			end
			pp = expected_q.pop_front();
			if (first.blue !== pp.first.blue || first.green !== pp.first.green ||
					first.red !== pp.first.red || second.blue !== pp.second.blue ||
					second.green !== pp.second.green || second.red !== pp.second.red ||
					fe !== pp.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected BGR %h %h end %b, got BGR %h %h end %b",
						pp.first, pp.second, pp.frame_end, first, second, fe);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] luma_first   = 8'd0;
	logic [7:0] chroma_blue  = 8'd0;
	logic [7:0] luma_second  = 8'd0;
	logic [7:0] chroma_red   = 8'd0;
	logic       frame_end_in = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] blue_first;
	logic [7:0] green_first;
	logic [7:0] red_first;
	logic [7:0] blue_second;
	logic [7:0] green_second;
	logic [7:0] red_second;
	logic       frame_end_out;

	rgb_scoreboard sb;
	int tx_count    = 0;
	int rx_count    = 0;
	int cycle_count = 0;

	yuy2_to_rgb24_converter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.luma_first   (luma_first),
		.chroma_blue  (chroma_blue),
		.luma_second  (luma_second),
		.chroma_red   (chroma_red),
		.frame_end_in (frame_end_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.blue_first   (blue_first),
		.green_first  (green_first),
		.red_first    (red_first),
		.blue_second  (blue_second),
		.green_second (green_second),
		.red_second   (red_second),
		.frame_end_out(frame_end_out)
	);

	// Clock
	initial begin
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("tb_yuy2_to_rgb24_converter: FAIL");
			$finish;
		end
	end

	// Transfer monitor: inputs noted before outputs are checked, same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(luma_first, chroma_blue, luma_second, chroma_red, frame_end_in);
			if (out_valid && !out_stall)
				sb.check_result({blue_first, green_first, red_first},
					{blue_second, green_second, red_second}, frame_end_out);
		end
	end

	// Idle length for one item; quiet stretches give back-to-back traffic
	function automatic int draw_idle(bit quiet);
		return quiet ? 0 : int'($urandom_range(0, MaxIdle));
	endfunction

	// Byte biased toward the corners of the conversion
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = 8'd0;
			1: b = 8'd255;
			2: b = 8'd16;
			3: b = 8'd235;
			4: b = 8'd128;
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// Drive one macropixel and hold it until the transfer
	task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] u,
			input logic [7:0] y1, input logic [7:0] v, input logic fe);
		int gap;
		gap = draw_idle(((tx_count / 37) % 4) == 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		luma_first   <= y0;
		chroma_blue  <= u;
		luma_second  <= y1;
		chroma_red   <= v;
		frame_end_in <= fe;
		do @(posedge clk); while (in_stall);
		tx_count++;
	endtask

	// Stop sending until every expected pair has come out; the extra edge lets the
	// monitor note the last input transfer first
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Receiver: random stall before each output transfer
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = draw_idle(((rx_count / 45) % 4) == 1);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			rx_count++;
		end
	end

	// Stimulus and end of run
	initial begin
		sb = new();
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, black and white, clamping, primaries, rounding
		send_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
		send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		send_macropixel(8'd16,  8'd128, 8'd16,  8'd128, 1'b0);
		send_macropixel(8'd235, 8'd128, 8'd235, 8'd128, 1'b0);
		send_macropixel(8'd0,   8'd128, 8'd15,  8'd128, 1'b0);
		send_macropixel(8'd255, 8'd0,   8'd255, 8'd0,   1'b0);
		send_macropixel(8'd128, 8'd0,   8'd128, 8'd255, 1'b0);
		send_macropixel(8'd128, 8'd255, 8'd128, 8'd0,   1'b1);
		send_macropixel(8'd16,  8'd0,   8'd235, 8'd0,   1'b0);
		send_macropixel(8'd16,  8'd255, 8'd235, 8'd255, 1'b0);
		send_macropixel(8'haa,  8'h55,  8'h55,  8'haa,  1'b1);
		send_macropixel(8'h55,  8'haa,  8'haa,  8'h55,  1'b0);
		send_macropixel(8'd81,  8'd90,  8'd81,  8'd240, 1'b0);
		send_macropixel(8'd145, 8'd54,  8'd145, 8'd34,  1'b0);
		send_macropixel(8'd41,  8'd240, 8'd41,  8'd110, 1'b0);
		send_macropixel(8'd17,  8'd129, 8'd17,  8'd127, 1'b0);
		send_macropixel(8'd1,   8'd2,   8'd254, 8'd253, 1'b1);
		send_macropixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);

		// Random macropixels, with one full drain in the middle
		for (int i = 0; i < RandomItems; i++) begin
			if (i == RandomItems / 2)
				hold_until_drained();
			send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
				$urandom_range(0, 15) == 0);
		end

		hold_until_drained();
		repeat (DrainCycles) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_yuy2_to_rgb24_converter: PASS");
		end else begin
			$display("tb_yuy2_to_rgb24_converter: FAIL");
		end
		$finish;
	end

endmodule
